@@ design/tms_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the touch mood state machine.
// No dependencies.
package tms_pkg;

    localparam int TIME_WIDTH_DEF = 32;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W = 3;

    localparam int T_POWER_ON_TICKS = 30;
    localparam int T_HAPPY_TICKS = 40;
    localparam int T_DEEP_BREATH_TICKS = 450;
    localparam int T_DISTURBED_TICKS = 70;
    localparam int T_COMFORT_REL_TICKS = 30;
    localparam int T_OFF_FADE_TICKS = 30;
    localparam int BATT_CHECK_TICKS = 50;

    typedef enum logic [3:0] {
        EMO_OFF       = 4'd0,
        EMO_POWER_ON  = 4'd1,
        EMO_CALM      = 4'd2,
        EMO_HAPPY     = 4'd3,
        EMO_COMFORT   = 4'd4,
        EMO_DEEP      = 4'd5,
        EMO_SLEEPY    = 4'd6,
        EMO_DISTURBED = 4'd7,
        EMO_LOW_BATT  = 4'd8,
        EMO_NIGHT     = 4'd9
    } mood_t;

    typedef enum logic [3:0] {
        EV_POWER_ON, EV_POWER_OFF, EV_SHORT, EV_HOLD, EV_BOTH_HOLD, EV_END,
        EV_RAPID, EV_BATT_LOW, EV_BATT_OK, EV_NIGHT
    } event_t;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0, OP_START = 2'd1, OP_POWER_OFF = 2'd2, OP_NIGHT = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        CFG_SHORT_TAP = 3'd0, CFG_HOLD_ONE = 3'd1, CFG_HOLD_BOTH = 3'd2,
        CFG_IDLE_SLEEP = 3'd3, CFG_RAPID_WIN = 3'd4, CFG_RAPID_CNT = 3'd5,
        CFG_BATT_LOW = 3'd6, CFG_BATT_REC = 3'd7
    } cfg_idx_t;

endpackage

@@ design/tms_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channels for input items and result items.
// No dependencies.
interface tms_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic       left_pressed;
    logic       right_pressed;
    logic       battery_ready;
    logic [6:0] battery_pct;
    modport source (output valid, opcode, left_pressed, right_pressed, battery_ready,
                    battery_pct, input ready);
    modport sink (input valid, opcode, left_pressed, right_pressed, battery_ready,
                  battery_pct, output ready);
endinterface

interface tms_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] mood;
    logic       state_changed;
    logic       shutdown_request;
    modport source (output valid, mood, state_changed, shutdown_request, input ready);
    modport sink (input valid, mood, state_changed, shutdown_request, output ready);
endinterface

@@ design/touch_mood_state_machine_top.sv @@
`timescale 1ns / 1ps
// Touch mood state machine: one result item per input item.
// Each accepted item's result is written to the result register; one item
// is accepted every cycle while the result register is empty or being taken.
// The whole tick update is one combinational pass over the state registers.
// Reset (asynchronous, active low) returns the mood to off, clears the behavior
// counters and flags and restores the register defaults.
module touch_mood_state_machine_top #(
    parameter int TIME_WIDTH = tms_pkg::TIME_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    tms_in_if.sink                         in_ch,
    tms_out_if.source                      out_ch,
    input  logic                           cfg_we,
    input  logic [tms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tms_pkg::CFG_DATA_W-1:0] cfg_data
);
    localparam int TW = TIME_WIDTH;

    typedef struct packed {
        tms_pkg::mood_t  mood;
        logic [TW-1:0]   entry;
        logic [TW-1:0]   crel;
        logic            crel_v;
        logic            sd_done;
    } ev_st_t;

    // Configuration registers.
    logic [7:0]  short_tap_reg;
    logic [9:0]  hold_one_reg, hold_both_reg, rapid_win_reg;
    logic [15:0] idle_sleep_reg;
    logic [3:0]  rapid_cnt_reg;
    logic [6:0]  batt_low_reg, batt_rec_reg;

    // Behavior state.
    ev_st_t        st_reg, st_next;
    logic [TW-1:0] tick_reg, tick_next, touch_reg, touch_next;
    logic [TW-1:0] ldown_reg, ldown_next, rdown_reg, rdown_next, bdown_reg, bdown_next;
    logic [TW-1:0] twin_reg, twin_next, bchk_reg, bchk_next;
    logic [3:0]    tcnt_reg, tcnt_next;
    logic          pl_reg, pl_next, pr_reg, pr_next;
    logic          lf_reg, lf_next, rf_reg, rf_next, bf_reg, bf_next;
    logic          bv_reg, bv_next, blow_reg, blow_next, run_reg, run_next;
    logic          pulse;

    logic          ov_reg;
    logic [3:0]    mood_out_reg;
    logic          chg_reg, sd_reg;
    logic          accept;

    function automatic logic t_ge(input logic [TW-1:0] a, input logic [TW-1:0] b,
                                  input logic [TW-1:0] k);
        logic [TW-1:0] d;
        d = a - b;
        return d >= k;
    endfunction

    function automatic ev_st_t chg(input ev_st_t s, input tms_pkg::mood_t m,
                                   input logic [TW-1:0] now);
        ev_st_t r;
        r = s;
        if (m != s.mood)
        begin
            r.mood = m;
            r.entry = now;
            r.crel_v = 1'b0;
            if (m == tms_pkg::EMO_OFF)
                r.sd_done = 1'b0;
        end
        return r;
    endfunction

    function automatic ev_st_t ev_apply(input ev_st_t s, input tms_pkg::event_t e,
                                        input logic [TW-1:0] now);
        ev_st_t r;
        r = s;
        if (e == tms_pkg::EV_POWER_OFF)
            r = chg(s, tms_pkg::EMO_OFF, now);
        else if (e == tms_pkg::EV_BATT_LOW && s.mood != tms_pkg::EMO_OFF
                 && s.mood != tms_pkg::EMO_LOW_BATT)
            r = chg(s, tms_pkg::EMO_LOW_BATT, now);
        else
        begin
            unique case (s.mood)
                tms_pkg::EMO_OFF:
                    if (e == tms_pkg::EV_POWER_ON) r = chg(s, tms_pkg::EMO_POWER_ON, now);
                tms_pkg::EMO_CALM:
                    priority if (e == tms_pkg::EV_SHORT) r = chg(s, tms_pkg::EMO_HAPPY, now);
                    else if (e == tms_pkg::EV_HOLD) r = chg(s, tms_pkg::EMO_COMFORT, now);
                    else if (e == tms_pkg::EV_BOTH_HOLD) r = chg(s, tms_pkg::EMO_DEEP, now);
                    else if (e == tms_pkg::EV_RAPID) r = chg(s, tms_pkg::EMO_DISTURBED, now);
                    else if (e == tms_pkg::EV_NIGHT) r = chg(s, tms_pkg::EMO_NIGHT, now);
                tms_pkg::EMO_COMFORT:
                    if (e == tms_pkg::EV_END)
                    begin
                        r.crel = now;
                        r.crel_v = 1'b1;
                    end
                tms_pkg::EMO_SLEEPY:
                    if (e == tms_pkg::EV_SHORT || e == tms_pkg::EV_HOLD
                        || e == tms_pkg::EV_BOTH_HOLD)
                        r = chg(s, tms_pkg::EMO_HAPPY, now);
                tms_pkg::EMO_LOW_BATT:
                    if (e == tms_pkg::EV_BATT_OK) r = chg(s, tms_pkg::EMO_CALM, now);
                tms_pkg::EMO_NIGHT:
                    if (e == tms_pkg::EV_NIGHT) r = chg(s, tms_pkg::EMO_CALM, now);
                default: r = s;
            endcase
        end
        return r;
    endfunction

    assign in_ch.ready = !ov_reg || out_ch.ready;
    assign accept = in_ch.valid && in_ch.ready;

    always_comb
    begin
        logic [TW-1:0] now;
        logic l, r, both, any, hold_zone;
        logic [1:0] rel;
        now = tick_reg;
        st_next = st_reg; tick_next = tick_reg; touch_next = touch_reg;
        ldown_next = ldown_reg; rdown_next = rdown_reg; bdown_next = bdown_reg;
        twin_next = twin_reg; bchk_next = bchk_reg; tcnt_next = tcnt_reg;
        pl_next = pl_reg; pr_next = pr_reg; lf_next = lf_reg; rf_next = rf_reg;
        bf_next = bf_reg; bv_next = bv_reg; blow_next = blow_reg; run_next = run_reg;
        pulse = 1'b0;
        l = in_ch.left_pressed; r = in_ch.right_pressed;
        both = l && r; any = l || r;
        rel = 2'b00; hold_zone = 1'b0;
        unique case (tms_pkg::opcode_t'(in_ch.opcode))
            tms_pkg::OP_TICK:
                if (run_reg)
                begin
                    now = tick_reg + 1'b1;
                    tick_next = now;
                    if (l && !pl_reg)
                    begin
                        ldown_next = now; lf_next = 1'b0; touch_next = now;
                    end
                    if (r && !pr_reg)
                    begin
                        rdown_next = now; rf_next = 1'b0; touch_next = now;
                    end
                    if (both && !bv_reg)
                    begin
                        bdown_next = now; bv_next = 1'b1;
                    end
                    if (!both)
                    begin
                        bv_next = 1'b0; bdown_next = '0; bf_next = 1'b0;
                    end
                    hold_zone = st_reg.mood == tms_pkg::EMO_CALM
                             || st_reg.mood == tms_pkg::EMO_SLEEPY;
                    if (hold_zone)
                    begin
                        if (l && !both && !lf_next
                            && t_ge(now, ldown_next, TW'(hold_one_reg)))
                        begin
                            lf_next = 1'b1;
                            st_next = ev_apply(st_next, tms_pkg::EV_HOLD, now);
                        end
                        if (r && !both && !rf_next
                            && t_ge(now, rdown_next, TW'(hold_one_reg)))
                        begin
                            rf_next = 1'b1;
                            st_next = ev_apply(st_next, tms_pkg::EV_HOLD, now);
                        end
                        if (both && !bf_next && bv_next
                            && t_ge(now, bdown_next, TW'(hold_both_reg)))
                        begin
                            bf_next = 1'b1;
                            st_next = ev_apply(st_next, tms_pkg::EV_BOTH_HOLD, now);
                        end
                    end
                    rel[0] = !l && pl_reg && !lf_next
                          && !t_ge(now, ldown_next, TW'(short_tap_reg));
                    rel[1] = !r && pr_reg && !rf_next
                          && !t_ge(now, rdown_next, TW'(short_tap_reg));
                    // Each released short tap is counted in the rapid-tap window.
                    for (int i = 0; i < 2; i++)
                    begin
                        if (rel[i])
                        begin
                            if (!t_ge(TW'(rapid_win_reg), now - twin_next, '0)
                                || (now - twin_next) > TW'(rapid_win_reg))
                            begin
                                tcnt_next = '0; twin_next = now;
                            end
                            tcnt_next = tcnt_next + 1'b1;
                            if (tcnt_next >= rapid_cnt_reg)
                            begin
                                tcnt_next = '0; twin_next = now;
                                st_next = ev_apply(st_next, tms_pkg::EV_RAPID, now);
                            end
                            else
                                st_next = ev_apply(st_next, tms_pkg::EV_SHORT, now);
                        end
                    end
                    if (!any && (pl_reg || pr_reg))
                        st_next = ev_apply(st_next, tms_pkg::EV_END, now);
                    pl_next = l; pr_next = r;
                    if (t_ge(now, bchk_reg, TW'(tms_pkg::BATT_CHECK_TICKS)))
                    begin
                        bchk_next = now;
                        if (in_ch.battery_ready)
                        begin
                            if (!blow_reg && in_ch.battery_pct < batt_low_reg)
                            begin
                                blow_next = 1'b1;
                                st_next = ev_apply(st_next, tms_pkg::EV_BATT_LOW, now);
                            end
                            else if (blow_reg && in_ch.battery_pct >= batt_rec_reg)
                            begin
                                blow_next = 1'b0;
                                st_next = ev_apply(st_next, tms_pkg::EV_BATT_OK, now);
                            end
                        end
                    end
                    unique case (st_next.mood)
                        tms_pkg::EMO_POWER_ON:
                            if (t_ge(now, st_next.entry, TW'(tms_pkg::T_POWER_ON_TICKS)))
                                st_next = chg(st_next, tms_pkg::EMO_CALM, now);
                        tms_pkg::EMO_CALM:
                            if (t_ge(now, touch_next, TW'(idle_sleep_reg)))
                                st_next = chg(st_next, tms_pkg::EMO_SLEEPY, now);
                        tms_pkg::EMO_HAPPY:
                            if (t_ge(now, st_next.entry, TW'(tms_pkg::T_HAPPY_TICKS)))
                                st_next = chg(st_next, tms_pkg::EMO_CALM, now);
                        tms_pkg::EMO_COMFORT:
                            if (st_next.crel_v && t_ge(now, st_next.crel,
                                TW'(tms_pkg::T_COMFORT_REL_TICKS)))
                                st_next = chg(st_next, tms_pkg::EMO_CALM, now);
                        tms_pkg::EMO_DEEP:
                            if (t_ge(now, st_next.entry, TW'(tms_pkg::T_DEEP_BREATH_TICKS)))
                                st_next = chg(st_next, tms_pkg::EMO_CALM, now);
                        tms_pkg::EMO_DISTURBED:
                            if (t_ge(now, st_next.entry, TW'(tms_pkg::T_DISTURBED_TICKS)))
                                st_next = chg(st_next, tms_pkg::EMO_CALM, now);
                        tms_pkg::EMO_OFF:
                            if (!st_next.sd_done
                                && t_ge(now, st_next.entry, TW'(tms_pkg::T_OFF_FADE_TICKS)))
                            begin
                                st_next.sd_done = 1'b1;
                                pulse = 1'b1;
                            end
                        default: st_next = st_next;
                    endcase
                end
            tms_pkg::OP_START:
                if (!run_reg)
                begin
                    run_next = 1'b1;
                    tick_next = '0;
                    touch_next = '0;
                    st_next = ev_apply(st_reg, tms_pkg::EV_POWER_ON, '0);
                end
            tms_pkg::OP_POWER_OFF:
                st_next = ev_apply(st_reg, tms_pkg::EV_POWER_OFF, tick_reg);
            tms_pkg::OP_NIGHT:
                st_next = ev_apply(st_reg, tms_pkg::EV_NIGHT, tick_reg);
            default: st_next = st_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_tap_reg <= 8'd10; hold_one_reg <= 10'd30; hold_both_reg <= 10'd50;
            idle_sleep_reg <= 16'd6000; rapid_win_reg <= 10'd50; rapid_cnt_reg <= 4'd3;
            batt_low_reg <= 7'd15; batt_rec_reg <= 7'd15;
        end
        else if (cfg_we)
        begin
            unique case (tms_pkg::cfg_idx_t'(cfg_index))
                tms_pkg::CFG_SHORT_TAP:  short_tap_reg <= cfg_data[7:0];
                tms_pkg::CFG_HOLD_ONE:   hold_one_reg <= cfg_data[9:0];
                tms_pkg::CFG_HOLD_BOTH:  hold_both_reg <= cfg_data[9:0];
                tms_pkg::CFG_IDLE_SLEEP: idle_sleep_reg <= cfg_data;
                tms_pkg::CFG_RAPID_WIN:  rapid_win_reg <= cfg_data[9:0];
                tms_pkg::CFG_RAPID_CNT:  rapid_cnt_reg <= cfg_data[3:0];
                tms_pkg::CFG_BATT_LOW:   batt_low_reg <= cfg_data[6:0];
                tms_pkg::CFG_BATT_REC:   batt_rec_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '{mood: tms_pkg::EMO_OFF, entry: '0, crel: '0,
                        crel_v: 1'b0, sd_done: 1'b0};
            tick_reg <= '0; touch_reg <= '0; ldown_reg <= '0; rdown_reg <= '0;
            bdown_reg <= '0; twin_reg <= '0; bchk_reg <= '0; tcnt_reg <= '0;
            pl_reg <= 1'b0; pr_reg <= 1'b0; lf_reg <= 1'b0; rf_reg <= 1'b0;
            bf_reg <= 1'b0; bv_reg <= 1'b0; blow_reg <= 1'b0; run_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                st_reg <= st_next; tick_reg <= tick_next; touch_reg <= touch_next;
                ldown_reg <= ldown_next; rdown_reg <= rdown_next; bdown_reg <= bdown_next;
                twin_reg <= twin_next; bchk_reg <= bchk_next; tcnt_reg <= tcnt_next;
                pl_reg <= pl_next; pr_reg <= pr_next; lf_reg <= lf_next; rf_reg <= rf_next;
                bf_reg <= bf_next; bv_reg <= bv_next; blow_reg <= blow_next;
                run_reg <= run_next;
                ov_reg <= 1'b1;
            end
            else if (out_ch.ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mood_out_reg <= st_next.mood;
            chg_reg <= st_next.mood != st_reg.mood;
            sd_reg <= pulse;
        end
    end

    assign out_ch.valid = ov_reg;
    assign out_ch.mood = mood_out_reg;
    assign out_ch.state_changed = chg_reg;
    assign out_ch.shutdown_request = sd_reg;

endmodule

@@ design/tms_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the touch mood state machine.
// Depends on tms_pkg and touch_mood_state_machine_top (bound below).
module tms_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] mood,
    input logic       state_changed,
    input logic       shutdown_request
);
    // A shutdown pulse only comes from a tick that stays in off.
    a_sd_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && shutdown_request |-> mood == tms_pkg::EMO_OFF && !state_changed)
        else $error("shutdown request outside off");

    // An accepted item always shows up as a result on the next cycle.
    a_accept_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted item produced no result");

    // The input side must not stall while the result register can drain.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("input stalled with free result register");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(mood))
        else $error("stalled result changed");
endmodule

bind touch_mood_state_machine_top tms_checker u_tms_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .mood(out_ch.mood), .state_changed(out_ch.state_changed),
    .shutdown_request(out_ch.shutdown_request)
);
